@@ design/afss_pkg.sv @@
`timescale 1ns / 1ps
package afss_pkg;

    // field and register widths
    localparam int COORD_W  = 32;
    localparam int DERIV_W  = 48;
    localparam int FOLD_W   = 28;
    localparam int SCALE_W  = 29;
    localparam int RAD_W    = 28;
    localparam int ZONE_W   = 2;
    localparam int CFG_W    = 29;
    localparam int CFG_IDX_W = 3;

    // internal widths
    localparam int FOLDED_W = 33;                 // folded coordinate, Q.24 signed
    localparam int MAG_W    = 32;                 // magnitude of a folded coordinate
    localparam int RR_W     = 2 * MAG_W;          // squared radius, Q.48
    localparam int SMAG_W   = SCALE_W;            // magnitude of the scale
    localparam int NUM_W    = SMAG_W + RAD_W;     // |scale| * max_radius_sq
    localparam int QUOT_W   = 40;                 // multiplier magnitude, Q.24
    localparam int FRAC_W   = 24;
    localparam int HALF_W   = 16;                 // operand slice for partial products
    localparam int PP_W     = HALF_W + QUOT_W;
    localparam int CPROD_W  = MAG_W + QUOT_W;
    localparam int DPROD_W  = DERIV_W + QUOT_W;
    localparam int CP_W     = CPROD_W - FRAC_W;
    localparam int DP_W     = DPROD_W - FRAC_W;

    // divider layout
    localparam int DIV_STEP   = 8;
    localparam int DIV_STAGES = QUOT_W / DIV_STEP;

    // fold zones
    localparam logic [ZONE_W-1:0] ZONE_OUT   = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_INNER = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_SHELL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_ZEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RSQ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RSQ  = 3'd6;

    // register reset values
    localparam logic [FOLD_W-1:0]  FOLD_RST  = 28'd8388608;
    localparam logic [SCALE_W-1:0] SCALE_RST = 29'd25165824;
    localparam logic [RAD_W-1:0]   MIN_RST   = 28'd4194304;
    localparam logic [RAD_W-1:0]   MAX_RST   = 28'd16777216;

    // saturation limits
    localparam logic [CP_W-1:0]    POS_LIM   = 48'h0000_7FFF_FFFF;
    localparam logic [CP_W-1:0]    NEG_LIM   = 48'h0000_8000_0000;
    localparam logic [DERIV_W-1:0] ONE_Q16   = 48'h0000_0001_0000;
    localparam logic [DP_W-1:0]    DERIV_TH  = 64'h0000_FFFF_FFFE_FFFF;

    typedef struct packed {
        logic signed [FOLD_W-1:0]  fold_x;
        logic signed [FOLD_W-1:0]  fold_y;
        logic signed [FOLD_W-1:0]  fold_z;
        logic                      fold_z_enable;
        logic signed [SCALE_W-1:0] scale;
        logic [RAD_W-1:0]          min_radius_sq;
        logic [RAD_W-1:0]          max_radius_sq;
    } cfg_t;

    // point data travelling alongside the divider
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;      // result sign per axis
        logic [DERIV_W-1:0]    deriv;
        logic [ZONE_W-1:0]     zone;
        logic                  sat;      // quotient overflows 40 bits
        logic [SMAG_W-1:0]     smag;
    } item_t;

    // restoring divider state: dividend bits shift out, quotient bits shift in
    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [QUOT_W-1:0] nq;
        logic [RAD_W-1:0]  dvsr;
    } dstep_t;

    function automatic logic signed [FOLDED_W-1:0] fold_axis(
        input logic signed [FOLD_W-1:0]  off,
        input logic signed [COORD_W-1:0] p
    );
        logic signed [FOLDED_W-1:0] pe;
        logic signed [FOLDED_W-1:0] ap;
        pe = FOLDED_W'(p);
        ap = p[COORD_W-1] ? -pe : pe;
        return FOLDED_W'(off) - ap;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [FOLDED_W-1:0] f);
        logic signed [FOLDED_W-1:0] n;
        n = -f;
        return f[FOLDED_W-1] ? n[MAG_W-1:0] : f[MAG_W-1:0];
    endfunction

endpackage

@@ design/afss_front.sv @@
`timescale 1ns / 1ps
module afss_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [afss_pkg::COORD_W-1:0] point_x,
    input  logic signed [afss_pkg::COORD_W-1:0] point_y,
    input  logic signed [afss_pkg::COORD_W-1:0] point_z,
    input  logic [afss_pkg::DERIV_W-1:0]        deriv_in,
    input  afss_pkg::cfg_t                      cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output afss_pkg::item_t                     item,
    output afss_pkg::dstep_t                    dstep
);
    import afss_pkg::*;

    logic [2:0] v_reg;
    logic [2:0] rdy;

    // stage 1: folds and scale numerator
    logic signed [FOLDED_W-1:0] f_reg [3];
    logic [DERIV_W-1:0]         deriv1_reg;
    logic [NUM_W-1:0]           num1_reg;
    logic [SMAG_W-1:0]          smag1_reg;
    logic                       mneg1_reg;

    // stage 2: magnitudes and squares
    logic [MAG_W-1:0]  mag2_reg [3];
    logic [2:0]        neg2_reg;
    logic [RR_W-1:0]   sq2_reg [3];
    logic [DERIV_W-1:0] deriv2_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [SMAG_W-1:0] smag2_reg;
    logic              mneg2_reg;

    // stage 3: zone and divider setup
    item_t  item_reg;
    dstep_t dstep_reg;

    logic [SMAG_W-1:0] smag;
    logic signed [FOLDED_W-1:0] fz_next;
    logic [RR_W-1:0]   rr;
    logic              inner;
    logic              shell;
    logic [RAD_W-1:0]  rr_q;
    logic [RAD_W-1:0]  dv;
    logic [RAD_W-1:0]  num_top;
    item_t             item_next;

    // stage flow control
    assign rdy[2]   = !v_reg[2] || out_ready;
    assign rdy[1]   = !v_reg[1] || rdy[2];
    assign rdy[0]   = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
        end
    end

    // stage 1
    assign smag    = cfg.scale[SCALE_W-1] ? SMAG_W'(-cfg.scale) : SMAG_W'(cfg.scale);
    assign fz_next = cfg.fold_z_enable ? fold_axis(cfg.fold_z, point_z)
                                       : FOLDED_W'(point_z);

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            f_reg[0]   <= fold_axis(cfg.fold_x, point_x);
            f_reg[1]   <= fold_axis(cfg.fold_y, point_y);
            f_reg[2]   <= fz_next;
            deriv1_reg <= deriv_in;
            num1_reg   <= NUM_W'(smag) * NUM_W'(cfg.max_radius_sq);
            smag1_reg  <= smag;
            mneg1_reg  <= cfg.scale[SCALE_W-1];
        end
    end

    // stage 2
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int k = 0; k < 3; k++) begin
                mag2_reg[k] <= mag_of(f_reg[k]);
                neg2_reg[k] <= f_reg[k][FOLDED_W-1];
                sq2_reg[k]  <= RR_W'(mag_of(f_reg[k])) * RR_W'(mag_of(f_reg[k]));
            end
            deriv2_reg <= deriv1_reg;
            num2_reg   <= num1_reg;
            smag2_reg  <= smag1_reg;
            mneg2_reg  <= mneg1_reg;
        end
    end

    // stage 3: radius sum, zone, divisor
    always_comb begin
        rr      = sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        inner   = rr < (RR_W'(cfg.min_radius_sq) << FRAC_W);
        shell   = rr < (RR_W'(cfg.max_radius_sq) << FRAC_W);
        rr_q    = rr[FRAC_W +: RAD_W];
        num_top = RAD_W'(num2_reg[NUM_W-1:QUOT_W]);
        if (inner) begin
            dv = cfg.min_radius_sq;
        end else if (shell && rr_q != '0) begin
            dv = rr_q;
        end else begin
            dv = RAD_W'(1);
        end
        item_next.mag   = {mag2_reg[2], mag2_reg[1], mag2_reg[0]};
        item_next.neg   = neg2_reg ^ {3{mneg2_reg}};
        item_next.deriv = deriv2_reg;
        item_next.zone  = inner ? ZONE_INNER : (shell ? ZONE_SHELL : ZONE_OUT);
        item_next.sat   = num_top >= dv;
        item_next.smag  = smag2_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            item_reg       <= item_next;
            dstep_reg.rem  <= num_top;
            dstep_reg.nq   <= num2_reg[QUOT_W-1:0];
            dstep_reg.dvsr <= dv;
        end
    end

    assign out_valid = v_reg[2];
    assign item      = item_reg;
    assign dstep     = dstep_reg;

endmodule

@@ design/afss_div_stage.sv @@
`timescale 1ns / 1ps
module afss_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  afss_pkg::item_t   item_in,
    input  afss_pkg::dstep_t  dstep_in,
    output logic              out_valid,
    input  logic              out_ready,
    output afss_pkg::item_t   item_out,
    output afss_pkg::dstep_t  dstep_out
);
    import afss_pkg::*;

    logic             v_reg;
    item_t            item_reg;
    dstep_t           dstep_reg;
    logic [RAD_W-1:0]  r;
    logic [QUOT_W-1:0] q;
    logic [RAD_W:0]    t;

    assign in_ready = !v_reg || out_ready;

    // eight restoring division steps
    always_comb begin
        r = dstep_in.rem;
        q = dstep_in.nq;
        t = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {r, q[QUOT_W-1]};
            q = {q[QUOT_W-2:0], 1'b0};
            if (t >= {1'b0, dstep_in.dvsr}) begin
                t    = t - {1'b0, dstep_in.dvsr};
                q[0] = 1'b1;
            end
            r = t[RAD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg       <= item_in;
            dstep_reg.rem  <= r;
            dstep_reg.nq   <= q;
            dstep_reg.dvsr <= dstep_in.dvsr;
        end
    end

    assign out_valid = v_reg;
    assign item_out  = item_reg;
    assign dstep_out = dstep_reg;

endmodule

@@ design/afss_back.sv @@
`timescale 1ns / 1ps
module afss_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  afss_pkg::item_t                        item,
    input  afss_pkg::dstep_t                       dstep,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0][afss_pkg::COORD_W-1:0]      new_coord,
    output logic [afss_pkg::DERIV_W-1:0]           deriv_out,
    output logic [afss_pkg::ZONE_W-1:0]            fold_zone
);
    import afss_pkg::*;

    logic [2:0] v_reg;
    logic [2:0] rdy;

    // stage 1: partial products
    logic [PP_W-1:0]   plo_reg [3];
    logic [PP_W-1:0]   phi_reg [3];
    logic [PP_W-1:0]   dpp_reg [3];
    logic [2:0]        neg1_reg;
    logic [ZONE_W-1:0] zone1_reg;

    // stage 2: summed products
    logic [CP_W-1:0]   p_reg [3];
    logic [DP_W-1:0]   dq_reg;
    logic [2:0]        neg2_reg;
    logic [ZONE_W-1:0] zone2_reg;

    // stage 3: saturated results
    logic [2:0][COORD_W-1:0] coord_reg;
    logic [DERIV_W-1:0]      deriv_reg;
    logic [ZONE_W-1:0]       zone3_reg;

    logic [QUOT_W-1:0]  mmag;
    logic [CPROD_W-1:0] cprod [3];
    logic [DPROD_W-1:0] dprod;
    logic [CP_W-1:0]    negp [3];

    assign rdy[2]   = !v_reg[2] || out_ready;
    assign rdy[1]   = !v_reg[1] || rdy[2];
    assign rdy[0]   = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
        end
    end

    // multiplier magnitude by zone
    always_comb begin
        if (item.zone == ZONE_OUT) begin
            mmag = QUOT_W'(item.smag);
        end else if (item.sat) begin
            mmag = '1;
        end else begin
            mmag = dstep.nq;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int k = 0; k < 3; k++) begin
                plo_reg[k] <= PP_W'(item.mag[k][HALF_W-1:0]) * PP_W'(mmag);
                phi_reg[k] <= PP_W'(item.mag[k][MAG_W-1:HALF_W]) * PP_W'(mmag);
                dpp_reg[k] <= PP_W'(item.deriv[k*HALF_W +: HALF_W]) * PP_W'(mmag);
            end
            neg1_reg  <= item.neg;
            zone1_reg <= item.zone;
        end
    end

    // product sums, truncated to Q.24 and Q.16
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cprod[k] = CPROD_W'(plo_reg[k]) + (CPROD_W'(phi_reg[k]) << HALF_W);
        end
        dprod = DPROD_W'(dpp_reg[0]) + (DPROD_W'(dpp_reg[1]) << HALF_W)
              + (DPROD_W'(dpp_reg[2]) << (2 * HALF_W));
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= cprod[k][CPROD_W-1:FRAC_W];
            end
            dq_reg    <= dprod[DPROD_W-1:FRAC_W];
            neg2_reg  <= neg1_reg;
            zone2_reg <= zone1_reg;
        end
    end

    // saturation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            negp[k] = (p_reg[k] > NEG_LIM) ? -NEG_LIM : -p_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int k = 0; k < 3; k++) begin
                if (neg2_reg[k]) begin
                    coord_reg[k] <= negp[k][COORD_W-1:0];
                end else if (p_reg[k] > POS_LIM) begin
                    coord_reg[k] <= POS_LIM[COORD_W-1:0];
                end else begin
                    coord_reg[k] <= p_reg[k][COORD_W-1:0];
                end
            end
            if (dq_reg >= DERIV_TH) begin
                deriv_reg <= '1;
            end else begin
                deriv_reg <= dq_reg[DERIV_W-1:0] + ONE_Q16;
            end
            zone3_reg <= zone2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign new_coord = coord_reg;
    assign deriv_out = deriv_reg;
    assign fold_zone = zone3_reg;

endmodule

@@ design/abs_fold_spherical_scale_step_core.sv @@
`timescale 1ns / 1ps
// One absolute-fold, spherical-fold and scale step of a box fractal in fixed point.
// A new point is accepted every cycle unless the pipeline stalls: three front stages
// fold, square and classify the point, five stages of a pipelined restoring divider
// (eight quotient bits each) form the spherical multiplier, and three back stages
// multiply, truncate and saturate. The pipeline stalls stage by stage from m_tready,
// so s_tready drops only once every stage is full. The user must write registers
// through cfg_wr_en/cfg_addr/cfg_wdata only while no point is in flight; the block
// does not enforce this. Unused register indexes are ignored.
module abs_fold_spherical_scale_step_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // x[31:0], y[63:32], z[95:64], deriv_in[143:96]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [143:0]                       s_tdata,
    // new_x[31:0], new_y[63:32], new_z[95:64], deriv_out[143:96]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [143:0]                       m_tdata,
    // fold_zone[1:0]
    output logic [afss_pkg::ZONE_W-1:0]        m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [afss_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [afss_pkg::CFG_W-1:0]         cfg_wdata
);
    import afss_pkg::*;

    cfg_t cfg_reg;

    logic   v_s   [DIV_STAGES+1];
    logic   r_s   [DIV_STAGES+1];
    item_t  item_s  [DIV_STAGES+1];
    dstep_t dstep_s [DIV_STAGES+1];

    logic [2:0][COORD_W-1:0] new_coord;
    logic [DERIV_W-1:0]      deriv_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fold_x        <= FOLD_RST;
            cfg_reg.fold_y        <= FOLD_RST;
            cfg_reg.fold_z        <= FOLD_RST;
            cfg_reg.fold_z_enable <= 1'b1;
            cfg_reg.scale         <= SCALE_RST;
            cfg_reg.min_radius_sq <= MIN_RST;
            cfg_reg.max_radius_sq <= MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FOLD_X:   cfg_reg.fold_x        <= cfg_wdata[FOLD_W-1:0];
                REG_FOLD_Y:   cfg_reg.fold_y        <= cfg_wdata[FOLD_W-1:0];
                REG_FOLD_Z:   cfg_reg.fold_z        <= cfg_wdata[FOLD_W-1:0];
                REG_FOLD_ZEN: cfg_reg.fold_z_enable <= cfg_wdata[0];
                REG_SCALE:    cfg_reg.scale         <= cfg_wdata[SCALE_W-1:0];
                REG_MIN_RSQ:  cfg_reg.min_radius_sq <= cfg_wdata[RAD_W-1:0];
                REG_MAX_RSQ:  cfg_reg.max_radius_sq <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // fold, square, classify
    afss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point_x   (s_tdata[31:0]),
        .point_y   (s_tdata[63:32]),
        .point_z   (s_tdata[95:64]),
        .deriv_in  (s_tdata[143:96]),
        .cfg       (cfg_reg),
        .out_valid (v_s[0]),
        .out_ready (r_s[0]),
        .item      (item_s[0]),
        .dstep     (dstep_s[0])
    );

    // divider pipeline
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        afss_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v_s[g]),
            .in_ready  (r_s[g]),
            .item_in   (item_s[g]),
            .dstep_in  (dstep_s[g]),
            .out_valid (v_s[g+1]),
            .out_ready (r_s[g+1]),
            .item_out  (item_s[g+1]),
            .dstep_out (dstep_s[g+1])
        );
    end

    // scale and saturate
    afss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_s[DIV_STAGES]),
        .in_ready  (r_s[DIV_STAGES]),
        .item      (item_s[DIV_STAGES]),
        .dstep     (dstep_s[DIV_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .new_coord (new_coord),
        .deriv_out (deriv_out),
        .fold_zone (m_tuser)
    );

    assign m_tdata = {deriv_out, new_coord[2], new_coord[1], new_coord[0]};

    // checks
    a_zone_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ZONE_OUT || m_tuser == ZONE_INNER || m_tuser == ZONE_SHELL))
        else $error("fold zone code out of range");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the result side is free");

    a_deriv_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[143:96] >= ONE_Q16))
        else $error("derivative result below one");

endmodule
